FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files that check their own behavior.
// Each macro expects the including module to have clk and an active-low rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication that is checked outside reset.
`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication that is checked outside reset.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/core/spq_pkg.sv
// Package for the sorted priority queue: sizes, operation and status codes,
// and the entry and control structs. Depends on nothing.
`default_nettype none

package spq_pkg;

    localparam int DEPTH      = 8;
    localparam int KEY_BITS   = 16;
    localparam int ID_BITS    = 16;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    localparam int FIELD_BITS  = 16;
    localparam int STATUS_BITS = 2;
    localparam int OCC_BITS    = 4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_POPPED    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [ID_BITS-1:0]  id;
    } spq_entry_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } spq_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/spq_cell.sv
// One slot of the sorted store: holds an entry and moves it left or right.
// Depends on spq_pkg.
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic       clk,
    input  wire spq_ctrl_t  ctrl,
    input  wire spq_entry_t new_entry,
    input  wire logic       occupied,
    input  wire spq_entry_t left_entry,
    input  wire logic       left_flag,
    input  wire spq_entry_t right_entry,
    output spq_entry_t      entry,
    output logic            flag
);

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // The flag marks this slot and every slot after it as at or behind the
    // insert position; the first set flag takes the new entry.
    assign flag  = !occupied || (entry_reg.key >= new_entry.key);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (left_flag)
            begin
                entry_next = left_entry;
            end
            else if (flag)
            begin
                entry_next = new_entry;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_priority_queue_top.sv
// Shortest-job-first ready queue built as a row of DEPTH shifting cells.
// Each command beat is an insert (cmd 0) or a pop (cmd 1) and yields exactly
// one result beat in the next cycle. An insert places the entry in front of the
// first held entry whose burst time is greater than or equal to its own, so
// the newest entry leads among equal keys; a pop returns the head entry, which
// has the smallest burst time. Every cell compares the incoming key with its
// own key in parallel and shifts by one place; the compare and shift in the
// cell row set the rate. The result sits in an output register, and a new
// command is accepted while the held result is being taken, so one command
// beat is taken per cycle unless the result side stalls. Inserts into a
// full queue and pops from an empty queue are rejected with status 2 and 3
// and leave the store unchanged; out_id and out_burst read zero except on
// a successful pop.
// Depends on spq_pkg, spq_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sorted_priority_queue_top
    import spq_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cmd_valid,
    output logic                        cmd_stall,
    input  wire logic                   cmd,
    input  wire logic [FIELD_BITS-1:0]  process_id,
    input  wire logic [FIELD_BITS-1:0]  burst_time,

    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic [FIELD_BITS-1:0]       out_id,
    output logic [FIELD_BITS-1:0]       out_burst,
    output logic [STATUS_BITS-1:0]      status,
    output logic [OCC_BITS-1:0]         occupancy
);

    logic                    accept;
    logic                    full;
    logic                    empty;
    spq_ctrl_t               ctrl;
    spq_entry_t              new_entry;

    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   count_next;

    logic                    result_valid_reg;
    logic                    result_valid_next;
    logic [FIELD_BITS-1:0]   out_id_reg;
    logic [FIELD_BITS-1:0]   out_id_next;
    logic [FIELD_BITS-1:0]   out_burst_reg;
    logic [FIELD_BITS-1:0]   out_burst_next;
    logic [STATUS_BITS-1:0]  status_reg;
    logic [STATUS_BITS-1:0]  status_next;

    spq_entry_t              cell_entry [DEPTH];
    logic                    cell_flag  [DEPTH];

    // A command beat is taken whenever the output register is empty or is
    // being emptied in the same cycle.
    assign cmd_stall = result_valid_reg && result_stall;
    assign accept    = cmd_valid && !cmd_stall;

    assign full  = (count_reg == COUNT_BITS'(DEPTH));
    assign empty = (count_reg == '0);

    assign ctrl.ins = accept && (cmd == CMD_INSERT) && !full;
    assign ctrl.pop = accept && (cmd == CMD_POP) && !empty;

    assign new_entry.key = KEY_BITS'(burst_time);
    assign new_entry.id  = ID_BITS'(process_id);

    // The row of cells. Slot zero is the head. Occupancy comes from the count,
    // so slots beyond it hold stale data that is never returned.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_entry_t left_e;
        logic       left_f;
        spq_entry_t right_e;

        if (i == 0)
        begin : g_head
            assign left_e = new_entry;
            assign left_f = 1'b0;
        end
        else
        begin : g_body
            assign left_e = cell_entry[i-1];
            assign left_f = cell_flag[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        spq_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .occupied    (count_reg > COUNT_BITS'(i)),
            .left_entry  (left_e),
            .left_flag   (left_f),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .flag        (cell_flag[i])
        );
    end

    always_comb
    begin
        count_next        = count_reg;
        result_valid_next = result_valid_reg;
        out_id_next       = out_id_reg;
        out_burst_next    = out_burst_reg;
        status_next       = status_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        if (accept)
        begin
            result_valid_next = 1'b1;
            out_id_next       = '0;
            out_burst_next    = '0;
            if (cmd == CMD_INSERT)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_INSERTED;
                    count_next  = count_reg + COUNT_BITS'(1);
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    status_next    = ST_POPPED;
                    count_next     = count_reg - COUNT_BITS'(1);
                    out_id_next    = FIELD_BITS'(cell_entry[0].id);
                    out_burst_next = FIELD_BITS'(cell_entry[0].key);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_id_reg    <= out_id_next;
        out_burst_reg <= out_burst_next;
        status_reg    <= status_next;
    end

    assign result_valid = result_valid_reg;
    assign out_id       = out_id_reg;
    assign out_burst    = out_burst_reg;
    assign status       = status_reg;
    assign occupancy    = OCC_BITS'(count_reg);

    // The count never passes the number of cells.
    `ASSERT_ALWAYS(a_count_bound, count_reg <= COUNT_BITS'(DEPTH), "count exceeds depth")

    // A pop that is taken from a non-empty queue drops the count by one.
    `ASSERT_NEXT(a_pop_count, accept && (cmd == CMD_POP) && !empty,
        count_reg == $past(count_reg) - COUNT_BITS'(1), "pop did not decrement count")

    // Only a successful pop carries entry data on the result side.
    `ASSERT_IMPLY(a_zero_fields, result_valid_reg && (status_reg != ST_POPPED),
        (out_id_reg == '0) && (out_burst_reg == '0), "non-pop result carries data")

    // The reported occupancy tracks the count while a result is held.
    `ASSERT_IMPLY(a_occ_match, result_valid_reg, occupancy == OCC_BITS'(count_reg),
        "occupancy differs from count")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for sorted_priority_queue_top, the shortest-job-first ready queue.
// Depends on spq_pkg for sizes and codes. Needs nothing else besides the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 20;
    localparam int LONG_HOLD    = 120;

    // One command beat as the driver presents it. A pause entry is not sent:
    // it holds the sender off until every outstanding result has come back.
    typedef struct {
        logic                  pause;
        logic                  op;
        logic [FIELD_BITS-1:0] pid;
        logic [FIELD_BITS-1:0] key;
    } sjf_cmd_t;

    // One result beat, packed so that a whole beat compares in one step.
    typedef struct packed {
        logic [FIELD_BITS-1:0]  id;
        logic [FIELD_BITS-1:0]  burst;
        logic [STATUS_BITS-1:0] status;
        logic [OCC_BITS-1:0]    occ;
    } sjf_result_t;

    // Receiver stall patterns and the insert/pop mixes of the random part.
    typedef enum int {RX_OPEN, RX_RANDOM, RX_CHOPPY} rx_mode_t;
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cmd_valid = 1'b0;
    logic                   cmd_stall;
    logic                   cmd = CMD_INSERT;
    logic [FIELD_BITS-1:0]  process_id = '0;
    logic [FIELD_BITS-1:0]  burst_time = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic [FIELD_BITS-1:0]  out_id;
    logic [FIELD_BITS-1:0]  out_burst;
    logic [STATUS_BITS-1:0] status;
    logic [OCC_BITS-1:0]    occupancy;

    sorted_priority_queue_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .process_id   (process_id),
        .burst_time   (burst_time),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_id       (out_id),
        .out_burst    (out_burst),
        .status       (status),
        .occupancy    (occupancy)
    );

    // Period of 10 ns: 5 ns low, then 5 ns high.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Commands waiting to be sent, and the results the queue still owes us,
    // oldest first.
    sjf_cmd_t    cmd_backlog[$];
    sjf_result_t owed_results[$];
    int          errors = 0;
    int          results_seen = 0;
    int          cycles = 0;

    // The testbench's own copy of the sorted store. Index 0 holds the entry
    // with the shortest burst time.
    spq_entry_t  ready_store[DEPTH];
    int          ready_count = 0;

    // Applies one command to the shadow store and returns the result beat the
    // queue must produce for it. An insert goes in front of the first entry
    // whose key is greater than or equal to its own, so among equal keys the
    // newest entry is the one popped first.
    function automatic sjf_result_t sjf_step(input logic op, input logic [FIELD_BITS-1:0] pid,
                                             input logic [FIELD_BITS-1:0] key);
        sjf_result_t r;
        int          pos;
        r = '0;
        if (op == CMD_INSERT)
        begin
            if (ready_count >= DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                pos = ready_count;
                for (int i = ready_count - 1; i >= 0; i--)
                begin
                    if (ready_store[i].key >= KEY_BITS'(key))
                    begin
                        pos = i;
                    end
                end
                for (int i = ready_count; i > pos; i--)
                begin
                    ready_store[i] = ready_store[i - 1];
                end
                ready_store[pos].key = KEY_BITS'(key);
                ready_store[pos].id  = ID_BITS'(pid);
                ready_count++;
                r.status = ST_INSERTED;
            end
        end
        else
        begin
            if (ready_count == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.id    = FIELD_BITS'(ready_store[0].id);
                r.burst = FIELD_BITS'(ready_store[0].key);
                for (int i = 1; i < ready_count; i++)
                begin
                    ready_store[i - 1] = ready_store[i];
                end
                ready_count--;
                r.status = ST_POPPED;
            end
        end
        r.occ = OCC_BITS'(ready_count);
        return r;
    endfunction

    function automatic sjf_cmd_t make_cmd(input logic op, input int pid, input int key);
        sjf_cmd_t c;
        c.pause = 1'b0;
        c.op    = op;
        c.pid   = FIELD_BITS'(pid);
        c.key   = FIELD_BITS'(key);
        return c;
    endfunction

    // Burst keys are drawn from a narrow range part of the time, so that
    // equal keys meet in the store often and the newest-first rule gets
    // exercised. The rest are extremes or full-range values.
    function automatic int pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            return $urandom_range(0, 7);
        end
        else if (r == 4)
        begin
            return ($urandom_range(0, 1) == 0) ? 0 : 16'hFFFF;
        end
        return $urandom_range(0, 16'hFFFF);
    endfunction

    // The handshake is sampled just before the rising edge, and the driver
    // acts on it at the following falling edge.
    logic cmd_fired = 1'b0;

    always @(posedge clk)
    begin
        cmd_fired <= rst_n && cmd_valid && !cmd_stall;
    end

    // Driver. It sends in bursts of random length and leaves random gaps
    // between them. A gap of zero joins two bursts, which gives stretches
    // where a beat is offered in every cycle. The payload of a stalled beat
    // is held until the beat is taken.
    sjf_cmd_t cur_cmd;
    int       burst_left = 1;
    int       gap_left = 0;

    always @(negedge clk)
    begin : drive
        logic load;
        if (rst_n)
        begin
            load = !cmd_valid;
            if (cmd_fired)
            begin
                owed_results.push_back(sjf_step(cur_cmd.op, cur_cmd.pid, cur_cmd.key));
                load = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (load)
            begin
                // A pause marker is dropped only once the queue owes nothing.
                while (cmd_backlog.size() != 0 && cmd_backlog[0].pause &&
                       owed_results.size() == 0)
                begin
                    void'(cmd_backlog.pop_front());
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0 && !cmd_backlog[0].pause)
                begin
                    cur_cmd = cmd_backlog.pop_front();
                    cmd_valid  <= 1'b1;
                    cmd        <= cur_cmd.op;
                    process_id <= cur_cmd.pid;
                    burst_time <= cur_cmd.key;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. It switches between stall patterns in segments of random
    // length. Twice it holds off for a long stretch while the sender keeps
    // offering beats, which fills the queue's pipeline and must push back on
    // the command side.
    rx_mode_t rx_mode = RX_OPEN;
    int       seg_left = 0;
    int       hold_left = 0;
    int       holds_done = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 100 : 500))
            begin
                hold_left = LONG_HOLD;
                holds_done++;
                result_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 2));
                    seg_left = $urandom_range(20, 80);
                end
                seg_left--;
                case (rx_mode)
                    RX_OPEN:   result_stall <= 1'b0;
                    RX_RANDOM: result_stall <= ($urandom_range(0, 2) == 0);
                    default:   result_stall <= !result_stall;
                endcase
            end
        end
    end

    // Monitor. Every result beat taken is checked against the oldest result
    // still owed.
    sjf_result_t got;
    sjf_result_t want;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            got = '{id: out_id, burst: out_burst, status: status, occ: occupancy};
            results_seen++;
            if (owed_results.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with none expected: id=%h burst=%h status=%0d occ=%0d",
                         $realtime, got.id, got.burst, got.status, got.occ);
            end
            else
            begin
                want = owed_results.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: mismatch, expected id=%h burst=%h status=%0d occ=%0d",
                             $realtime, want.id, want.burst, want.status, want.occ);
                    $display("%0t:           actual   id=%h burst=%h status=%0d occ=%0d",
                             $realtime, got.id, got.burst, got.status, got.occ);
                end
            end
        end
    end

    // Watchdog. The limit is far above the slowest correct run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        sjf_cmd_t pause_cmd;
        mix_t     mix;
        int       p_insert;
        pause_cmd = '{pause: 1'b1, op: CMD_INSERT, pid: '0, key: '0};
        mix = MIX_EVEN;
        p_insert = 50;

        // Directed part. A pop on the empty queue comes first. Then eight
        // inserts fill the store with the extreme keys and ids and several
        // runs of equal keys, an insert into the full queue is rejected, eight
        // pops empty it in key order, and one more pop finds it empty.
        cmd_backlog.push_back(make_cmd(CMD_POP, 16'hFFFF, 16'hFFFF));
        cmd_backlog.push_back(make_cmd(CMD_INSERT, 16'hFFFF, 16'hFFFF));
        cmd_backlog.push_back(make_cmd(CMD_INSERT, 16'h0000, 16'h0000));
        cmd_backlog.push_back(make_cmd(CMD_INSERT, 16'h0A01, 16'h8000));
        cmd_backlog.push_back(make_cmd(CMD_INSERT, 16'h0A02, 16'h8000));
        cmd_backlog.push_back(make_cmd(CMD_INSERT, 16'h5555, 16'h0001));
        cmd_backlog.push_back(make_cmd(CMD_INSERT, 16'h0A03, 16'h8000));
        cmd_backlog.push_back(make_cmd(CMD_INSERT, 16'hAAAA, 16'h7FFF));
        cmd_backlog.push_back(make_cmd(CMD_INSERT, 16'h1234, 16'hFFFF));
        cmd_backlog.push_back(make_cmd(CMD_INSERT, 16'hBEEF, 16'h0000));
        for (int n = 0; n < DEPTH; n++)
        begin
            cmd_backlog.push_back(make_cmd(CMD_POP, 0, 0));
        end
        cmd_backlog.push_back(make_cmd(CMD_POP, 16'h00FF, 16'hFF00));
        cmd_backlog.push_back(pause_cmd);

        // Random part. The insert/pop mix changes every forty items, so the
        // queue climbs to full, drains to empty and hovers in between. Pops
        // carry random id and key bits that the queue must ignore. Halfway
        // through, the sender waits for every owed result.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                mix = mix_t'($urandom_range(0, 2));
                p_insert = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 20 : 50;
            end
            if (n == RANDOM_ITEMS / 2)
            begin
                cmd_backlog.push_back(pause_cmd);
            end
            cmd_backlog.push_back(make_cmd(($urandom_range(0, 99) < p_insert) ? CMD_INSERT : CMD_POP,
                                           $urandom_range(0, 16'hFFFF), pick_key()));
        end

        // Reset is held from the start and released on a falling edge.
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Wait until every command has been taken and every result has come,
        // then give the queue some cycles to show any stray result beat.
        while (cmd_backlog.size() != 0 || cmd_valid)
        begin
            @(posedge clk);
        end
        while (owed_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
